### design/ddf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddf_pkg: shared types, widths and constants of the diode-ladder derivative
// Fixed-point formats, stream item layouts, pipeline stage loads and the
// constant tanh table, built at elaboration with exact integer arithmetic.
// ----------------------------------------------------------------------------
package ddf_pkg;

   // Value formats
   localparam int VALUE_W      = 24;                   // signed Q8.16
   localparam int CTRL_W       = VALUE_W - 1;          // unsigned Q7.16
   localparam int FRAC_W       = 16;
   localparam int FC_W         = CTRL_W + 3;           // 4*K + 0.5
   localparam int FB_PROD_W    = FC_W + 1 + VALUE_W;
   localparam int VFB_W        = FB_PROD_W - FRAC_W;
   localparam int DIFF_W       = VFB_W + 1;

   // Any difference beyond this window already drives tanh into saturation
   localparam int ARG_IN_W     = 21;
   localparam int RECIP_W      = 21;
   localparam int ARG_PROD_W   = ARG_IN_W + RECIP_W + 1;
   localparam int ARG_W        = ARG_PROD_W - FRAC_W;
   localparam int FOUR_W       = FRAC_W + 2;           // bits below 4.0

   localparam int TANH_DEPTH   = 256;
   localparam int TANH_ADDR_W  = $clog2(TANH_DEPTH);
   localparam int POS_W        = FOUR_W + TANH_ADDR_W;
   localparam int TANH_Y_W     = FRAC_W + 1;
   localparam int INTERP_W     = TANH_Y_W + FOUR_W;
   localparam int INTERP_SUM_W = INTERP_W + 1;
   localparam int TANH_OUT_W   = TANH_Y_W + 1;

   localparam int GAIN_W       = CTRL_W;
   localparam int CUT_PROD_W   = CTRL_W + FRAC_W;
   localparam int SUM_W        = TANH_OUT_W + 1;
   localparam int DERIV_PROD_W = GAIN_W + 1 + SUM_W;
   localparam int DERIV_W      = 32;
   localparam int NUM_LANES    = 4;

   localparam int NUM_STAGES   = 8;

   // Constants
   localparam int HALF_Q16 = 2 ** (FRAC_W - 1);
   localparam int HALF_POS = 2 ** (FOUR_W - 1);
   localparam logic [FRAC_W-1:0]   CUT_GAIN  = FRAC_W'(54526);     // 0.832
   localparam logic [FC_W-1:0]     FB_OFFSET = FC_W'(32768);       // 0.5
   localparam logic [RECIP_W-1:0]  RECIP_VT2 = RECIP_W'(1260308);  // 1/0.052
   localparam logic [RECIP_W-1:0]  RECIP_G2  = RECIP_W'(686442);   // 1/0.095472
   localparam logic [RECIP_W-1:0]  RECIP_G6  = RECIP_W'(228814);   // 1/0.286416
   localparam logic [TANH_Y_W-1:0] TANH_ONE  = TANH_Y_W'(65536);
   localparam logic signed [DIFF_W-1:0] ARG_IN_MAX = DIFF_W'(2 ** (ARG_IN_W - 1) - 1);
   localparam logic signed [DIFF_W-1:0] ARG_IN_MIN = ~ARG_IN_MAX;

   // Stream layouts
   localparam int REQ_FIELD_W = 5 * VALUE_W + 2 * CTRL_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int REQ_PAD_W   = REQ_TDATA_W - REQ_FIELD_W;
   localparam int RSP_TDATA_W = NUM_LANES * DERIV_W;

   typedef struct packed {
      logic [REQ_PAD_W-1:0]      pad;
      logic signed [VALUE_W-1:0] volt_c4;
      logic signed [VALUE_W-1:0] volt_c3;
      logic signed [VALUE_W-1:0] volt_c2;
      logic signed [VALUE_W-1:0] volt_c1;
      logic [CTRL_W-1:0]         resonance;
      logic [CTRL_W-1:0]         cutoff;
      logic signed [VALUE_W-1:0] sample_in;
   } req_item_type;

   typedef struct packed {
      logic signed [DERIV_W-1:0] deriv_c4;
      logic signed [DERIV_W-1:0] deriv_c3;
      logic signed [DERIV_W-1:0] deriv_c2;
      logic signed [DERIV_W-1:0] deriv_c1;
   } rsp_item_type;

   // One load enable per register stage, first stage in the lowest bit
   typedef struct packed {
      logic back_out;
      logic back_mul;
      logic tanh_out;
      logic tanh_interp;
      logic tanh_look;
      logic tanh_mul;
      logic front_fb;
      logic front_in;
   } stage_load_type;

   typedef logic [TANH_Y_W-1:0] tanh_full_type [0:TANH_DEPTH];
   typedef logic [TANH_Y_W-1:0] tanh_table_type [0:TANH_DEPTH-1];

   // Clamp a difference into the tanh argument window
   function automatic logic signed [ARG_IN_W-1:0] clamp_arg(
      input logic signed [DIFF_W-1:0] v);
      if (v > ARG_IN_MAX) begin
         return ARG_IN_MAX[ARG_IN_W-1:0];
      end else if (v < ARG_IN_MIN) begin
         return ARG_IN_MIN[ARG_IN_W-1:0];
      end
      return v[ARG_IN_W-1:0];
   endfunction

   // Division by the series term index, elaboration only
   function automatic longint unsigned div_small(input longint unsigned x, input int n);
      case (n)
         2:  return x / 2;
         3:  return x / 3;
         4:  return x / 4;
         5:  return x / 5;
         6:  return x / 6;
         7:  return x / 7;
         8:  return x / 8;
         9:  return x / 9;
         10: return x / 10;
         11: return x / 11;
         12: return x / 12;
         13: return x / 13;
         14: return x / 14;
         15: return x / 15;
         16: return x / 16;
         17: return x / 17;
         18: return x / 18;
         19: return x / 19;
         20: return x / 20;
         21: return x / 21;
         22: return x / 22;
         23: return x / 23;
         24: return x / 24;
         default: return x;
      endcase
   endfunction

   // tanh(4i/DEPTH) in Q16: exp series in Q31, three squarings, then the
   // ratio (1-e)/(1+e) rounded to nearest by shift-and-subtract division
   function automatic tanh_full_type build_tanh_full();
      tanh_full_type     tbl;
      longint            sum;
      longint            e;
      longint            num;
      longint            den;
      longint            rem;
      longint            dvs;
      longint unsigned   t;
      logic [FOUR_W-1:0] q;
      for (int i = 0; i <= TANH_DEPTH; i++) begin
         sum = longint'(1) <<< 31;
         t   = 64'd1 << 31;
         for (int n = 1; n <= 24; n++) begin
            t = div_small((t * 64'(i)) / TANH_DEPTH, n);
            if (n[0]) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
         end
         e = (sum < 0) ? 0 : ((sum > (longint'(1) <<< 31)) ? (longint'(1) <<< 31) : sum);
         for (int s = 0; s < 3; s++) begin
            e = (e * e + (longint'(1) <<< 30)) >>> 31;
         end
         num = (longint'(1) <<< 31) - e;
         den = (longint'(1) <<< 31) + e;
         rem = (num <<< 17) + den;
         dvs = den <<< 1;
         q   = '0;
         for (int b = FOUR_W - 1; b >= 0; b--) begin
            if (rem >= (dvs <<< b)) begin
               rem  = rem - (dvs <<< b);
               q[b] = 1'b1;
            end
         end
         tbl[i] = q[TANH_Y_W-1:0];
      end
      return tbl;
   endfunction

   function automatic tanh_table_type tanh_lo_of(input tanh_full_type f);
      tanh_table_type r;
      for (int i = 0; i < TANH_DEPTH; i++) begin
         r[i] = f[i];
      end
      return r;
   endfunction

   function automatic tanh_table_type tanh_step_of(input tanh_full_type f);
      tanh_table_type r;
      for (int i = 0; i < TANH_DEPTH; i++) begin
         r[i] = f[i+1] - f[i];
      end
      return r;
   endfunction

   localparam tanh_full_type  TANH_FULL = build_tanh_full();
   localparam tanh_table_type TANH_LO   = tanh_lo_of(TANH_FULL);
   localparam tanh_table_type TANH_STEP = tanh_step_of(TANH_FULL);

endpackage
`default_nettype wire

### design/ddf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddf_ctrl: valid chain of the derivative pipeline
// Tracks one valid bit per stage and lets each stage advance when the stage
// after it is empty or moving, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module ddf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ddf_pkg::stage_load_type    load
);

   logic [ddf_pkg::NUM_STAGES:1]   valid_ff;
   logic [ddf_pkg::NUM_STAGES:1]   valid_in;
   logic [ddf_pkg::NUM_STAGES+1:1] advance;
   logic [ddf_pkg::NUM_STAGES:0]   valid_up;
   logic [ddf_pkg::NUM_STAGES:1]   load_vec;

   always_comb begin
      advance[ddf_pkg::NUM_STAGES+1] = out_ready;
      for (int k = ddf_pkg::NUM_STAGES; k >= 1; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
      valid_up = {valid_ff, in_valid};
      for (int k = 1; k <= ddf_pkg::NUM_STAGES; k++) begin
         valid_in[k] = advance[k] ? valid_up[k-1] : valid_ff[k];
         load_vec[k] = advance[k] && valid_up[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = advance[1];
   assign out_valid = valid_ff[ddf_pkg::NUM_STAGES];
   assign load      = ddf_pkg::stage_load_type'(load_vec);

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> &valid_ff)
      else $error("input blocked while a stage is empty");

   a_ready_passes: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> in_ready)
      else $error("output ready did not reach the input");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[1])
      else $error("accepted item missing from first stage");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(valid_ff) == $past($countones(valid_ff))
         + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)))
      else $error("item lost or duplicated in the pipeline");

endmodule
`default_nettype wire

### design/ddf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddf_front: feedback, gain and tanh argument differences
// Two stages: products of feedback and cutoff gain with the clamped capacitor
// differences, then rounding and the input-minus-feedback difference. All differences leave clamped.
// ----------------------------------------------------------------------------
module ddf_front (
   input  wire logic                                clock,
   input  wire ddf_pkg::stage_load_type             load,
   input  wire ddf_pkg::req_item_type               item,
   output logic signed [ddf_pkg::ARG_IN_W-1:0]      diff_a,
   output logic signed [ddf_pkg::ARG_IN_W-1:0]      diff_b,
   output logic signed [ddf_pkg::ARG_IN_W-1:0]      diff_c,
   output logic signed [ddf_pkg::ARG_IN_W-1:0]      diff_d,
   output logic signed [ddf_pkg::ARG_IN_W-1:0]      diff_e,
   output logic [ddf_pkg::GAIN_W-1:0]               gain
);

   logic [ddf_pkg::FC_W-1:0]                fc;
   logic signed [ddf_pkg::FB_PROD_W-1:0]    fb_prod_in,  fb_prod_ff;
   logic [ddf_pkg::CUT_PROD_W-1:0]          cut_prod_in, cut_prod_ff;
   logic signed [ddf_pkg::VALUE_W-1:0]      sample_ff;
   logic signed [ddf_pkg::ARG_IN_W-1:0]     diff_b_s1_in, diff_b_s1_ff;
   logic signed [ddf_pkg::ARG_IN_W-1:0]     diff_c_s1_in, diff_c_s1_ff;
   logic signed [ddf_pkg::ARG_IN_W-1:0]     diff_d_s1_in, diff_d_s1_ff;
   logic signed [ddf_pkg::ARG_IN_W-1:0]     diff_e_s1_in, diff_e_s1_ff;

   logic [ddf_pkg::FB_PROD_W-1:0]           fb_round;
   logic signed [ddf_pkg::VFB_W-1:0]        vfb;
   logic [ddf_pkg::CUT_PROD_W-1:0]          cut_round;
   logic signed [ddf_pkg::ARG_IN_W-1:0]     diff_a_in, diff_a_ff;
   logic [ddf_pkg::GAIN_W-1:0]              gain_in,   gain_ff;
   logic signed [ddf_pkg::ARG_IN_W-1:0]     diff_b_ff, diff_c_ff, diff_d_ff, diff_e_ff;

   // First stage: feedback product, gain product, capacitor differences
   always_comb begin
      fc           = ddf_pkg::FC_W'({item.resonance, 2'b00}) + ddf_pkg::FB_OFFSET;
      fb_prod_in   = ddf_pkg::FB_PROD_W'($signed({1'b0, fc}))
                   * ddf_pkg::FB_PROD_W'(item.volt_c4);
      cut_prod_in  = ddf_pkg::CUT_PROD_W'(item.cutoff)
                   * ddf_pkg::CUT_PROD_W'(ddf_pkg::CUT_GAIN);
      diff_b_s1_in = ddf_pkg::clamp_arg(ddf_pkg::DIFF_W'(item.volt_c2)
                                      - ddf_pkg::DIFF_W'(item.volt_c1));
      diff_c_s1_in = ddf_pkg::clamp_arg(ddf_pkg::DIFF_W'(item.volt_c3)
                                      - ddf_pkg::DIFF_W'(item.volt_c2));
      diff_d_s1_in = ddf_pkg::clamp_arg(ddf_pkg::DIFF_W'(item.volt_c4)
                                      - ddf_pkg::DIFF_W'(item.volt_c3));
      diff_e_s1_in = ddf_pkg::clamp_arg(ddf_pkg::DIFF_W'(item.volt_c4));
   end

   // Second stage: round feedback and gain, form the input difference
   always_comb begin
      fb_round  = fb_prod_ff + ddf_pkg::FB_PROD_W'(ddf_pkg::HALF_Q16);
      vfb       = $signed(fb_round[ddf_pkg::FB_PROD_W-1:ddf_pkg::FRAC_W]);
      diff_a_in = ddf_pkg::clamp_arg(ddf_pkg::DIFF_W'(sample_ff) - ddf_pkg::DIFF_W'(vfb));
      cut_round = cut_prod_ff + ddf_pkg::CUT_PROD_W'(ddf_pkg::HALF_Q16);
      gain_in   = cut_round[ddf_pkg::CUT_PROD_W-1:ddf_pkg::FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (load.front_in) begin
         fb_prod_ff   <= fb_prod_in;
         cut_prod_ff  <= cut_prod_in;
         sample_ff    <= item.sample_in;
         diff_b_s1_ff <= diff_b_s1_in;
         diff_c_s1_ff <= diff_c_s1_in;
         diff_d_s1_ff <= diff_d_s1_in;
         diff_e_s1_ff <= diff_e_s1_in;
      end
      if (load.front_fb) begin
         diff_a_ff <= diff_a_in;
         gain_ff   <= gain_in;
         diff_b_ff <= diff_b_s1_ff;
         diff_c_ff <= diff_c_s1_ff;
         diff_d_ff <= diff_d_s1_ff;
         diff_e_ff <= diff_e_s1_ff;
      end
   end

   assign diff_a = diff_a_ff;
   assign diff_b = diff_b_ff;
   assign diff_c = diff_c_ff;
   assign diff_d = diff_d_ff;
   assign diff_e = diff_e_ff;
   assign gain   = gain_ff;

endmodule
`default_nettype wire

### design/ddf_tanh.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddf_tanh: scaled tanh by table lookup and linear interpolation
// Four stages: scale by reciprocal, index the table, interpolate, sign.
// ----------------------------------------------------------------------------
module ddf_tanh (
   input  wire logic                                clock,
   input  wire ddf_pkg::stage_load_type             load,
   input  wire logic signed [ddf_pkg::ARG_IN_W-1:0] diff,
   input  wire logic [ddf_pkg::RECIP_W-1:0]         recip,
   output logic signed [ddf_pkg::TANH_OUT_W-1:0]    y
);

   logic signed [ddf_pkg::ARG_PROD_W-1:0] prod_in, prod_ff;

   logic [ddf_pkg::ARG_PROD_W-1:0]        arg_round;
   logic signed [ddf_pkg::ARG_W-1:0]      arg;
   logic [ddf_pkg::ARG_W-1:0]             mag;
   logic [ddf_pkg::POS_W-1:0]             pos;
   logic [ddf_pkg::TANH_ADDR_W-1:0]       idx;
   logic                                  neg_in,  neg_ff;
   logic                                  sat_in,  sat_ff;
   logic [ddf_pkg::TANH_Y_W-1:0]          lo_in,   lo_ff;
   logic [ddf_pkg::TANH_Y_W-1:0]          step_in, step_ff;
   logic [ddf_pkg::FOUR_W-1:0]            frac_in, frac_ff;

   logic [ddf_pkg::INTERP_W-1:0]          interp_in, interp_ff;
   logic                                  neg_i_ff, sat_i_ff;
   logic [ddf_pkg::TANH_Y_W-1:0]          lo_i_ff;

   logic [ddf_pkg::INTERP_SUM_W-1:0]      interp_round;
   logic [ddf_pkg::TANH_Y_W-1:0]          y_mag;
   logic signed [ddf_pkg::TANH_OUT_W-1:0] y_in, y_ff;

   assign prod_in = ddf_pkg::ARG_PROD_W'(diff)
                  * ddf_pkg::ARG_PROD_W'($signed({1'b0, recip}));

   // Round to Q16, split sign and magnitude, look up the segment
   always_comb begin
      arg_round = prod_ff + ddf_pkg::ARG_PROD_W'(ddf_pkg::HALF_Q16);
      arg       = $signed(arg_round[ddf_pkg::ARG_PROD_W-1:ddf_pkg::FRAC_W]);
      neg_in    = arg[ddf_pkg::ARG_W-1];
      mag       = neg_in ? ddf_pkg::ARG_W'(-arg) : ddf_pkg::ARG_W'(arg);
      sat_in    = |mag[ddf_pkg::ARG_W-1:ddf_pkg::FOUR_W];
      pos       = ddf_pkg::POS_W'(mag[ddf_pkg::FOUR_W-1:0])
                * ddf_pkg::POS_W'(ddf_pkg::TANH_DEPTH);
      idx       = pos[ddf_pkg::POS_W-1:ddf_pkg::FOUR_W];
      frac_in   = pos[ddf_pkg::FOUR_W-1:0];
      lo_in     = ddf_pkg::TANH_LO[idx];
      step_in   = ddf_pkg::TANH_STEP[idx];
   end

   assign interp_in = ddf_pkg::INTERP_W'(step_ff) * ddf_pkg::INTERP_W'(frac_ff);

   // Add the rounded slope term, saturate at four, restore the sign
   always_comb begin
      interp_round = ddf_pkg::INTERP_SUM_W'(interp_ff)
                   + ddf_pkg::INTERP_SUM_W'(ddf_pkg::HALF_POS);
      y_mag = sat_i_ff ? ddf_pkg::TANH_ONE
            : lo_i_ff + ddf_pkg::TANH_Y_W'(interp_round[ddf_pkg::INTERP_SUM_W-1:ddf_pkg::FOUR_W]);
      y_in  = neg_i_ff ? -$signed(ddf_pkg::TANH_OUT_W'(y_mag))
                       :  $signed(ddf_pkg::TANH_OUT_W'(y_mag));
   end

   always_ff @(posedge clock) begin
      if (load.tanh_mul) begin
         prod_ff <= prod_in;
      end
      if (load.tanh_look) begin
         neg_ff  <= neg_in;
         sat_ff  <= sat_in;
         lo_ff   <= lo_in;
         step_ff <= step_in;
         frac_ff <= frac_in;
      end
      if (load.tanh_interp) begin
         interp_ff <= interp_in;
         neg_i_ff  <= neg_ff;
         sat_i_ff  <= sat_ff;
         lo_i_ff   <= lo_ff;
      end
      if (load.tanh_out) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule
`default_nettype wire

### design/ddf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddf_back: combine tanh terms and scale by the cutoff gain
// Delays the gain alongside the tanh stages, then multiplies and rounds.
// ----------------------------------------------------------------------------
module ddf_back (
   input  wire logic                                  clock,
   input  wire ddf_pkg::stage_load_type               load,
   input  wire logic [ddf_pkg::GAIN_W-1:0]            gain,
   input  wire logic signed [ddf_pkg::TANH_OUT_W-1:0] y_a,
   input  wire logic signed [ddf_pkg::TANH_OUT_W-1:0] y_b,
   input  wire logic signed [ddf_pkg::TANH_OUT_W-1:0] y_c,
   input  wire logic signed [ddf_pkg::TANH_OUT_W-1:0] y_d,
   input  wire logic signed [ddf_pkg::TANH_OUT_W-1:0] y_e,
   output ddf_pkg::rsp_item_type                      item
);

   logic [ddf_pkg::GAIN_W-1:0]              gain_s3_ff, gain_s4_ff, gain_s5_ff, gain_s6_ff;
   logic signed [ddf_pkg::SUM_W-1:0]        sum      [ddf_pkg::NUM_LANES];
   logic signed [ddf_pkg::DERIV_PROD_W-1:0] prod_in  [ddf_pkg::NUM_LANES];
   logic signed [ddf_pkg::DERIV_PROD_W-1:0] prod_ff  [ddf_pkg::NUM_LANES];
   logic [ddf_pkg::DERIV_PROD_W-1:0]        rnd      [ddf_pkg::NUM_LANES];
   logic signed [ddf_pkg::DERIV_W-1:0]      deriv_in [ddf_pkg::NUM_LANES];
   logic signed [ddf_pkg::DERIV_W-1:0]      deriv_ff [ddf_pkg::NUM_LANES];

   always_comb begin
      sum[0] =  ddf_pkg::SUM_W'(y_a) + ddf_pkg::SUM_W'(y_b);
      sum[1] =  ddf_pkg::SUM_W'(y_c) - ddf_pkg::SUM_W'(y_b);
      sum[2] =  ddf_pkg::SUM_W'(y_d) - ddf_pkg::SUM_W'(y_c);
      sum[3] = -ddf_pkg::SUM_W'(y_e) - ddf_pkg::SUM_W'(y_d);
      for (int i = 0; i < ddf_pkg::NUM_LANES; i++) begin
         prod_in[i] = ddf_pkg::DERIV_PROD_W'($signed({1'b0, gain_s6_ff}))
                    * ddf_pkg::DERIV_PROD_W'(sum[i]);
      end
   end

   // The rounded product stays within 2^25, so the 32-bit limits are never
   // reached and sign extension is the saturated value
   always_comb begin
      for (int i = 0; i < ddf_pkg::NUM_LANES; i++) begin
         rnd[i]      = prod_ff[i] + ddf_pkg::DERIV_PROD_W'(ddf_pkg::HALF_Q16);
         deriv_in[i] = ddf_pkg::DERIV_W'($signed(
                          rnd[i][ddf_pkg::DERIV_PROD_W-1:ddf_pkg::FRAC_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (load.tanh_mul) begin
         gain_s3_ff <= gain;
      end
      if (load.tanh_look) begin
         gain_s4_ff <= gain_s3_ff;
      end
      if (load.tanh_interp) begin
         gain_s5_ff <= gain_s4_ff;
      end
      if (load.tanh_out) begin
         gain_s6_ff <= gain_s5_ff;
      end
      if (load.back_mul) begin
         prod_ff <= prod_in;
      end
      if (load.back_out) begin
         deriv_ff <= deriv_in;
      end
   end

   always_comb begin
      item.deriv_c1 = deriv_ff[0];
      item.deriv_c2 = deriv_ff[1];
      item.deriv_c3 = deriv_ff[2];
      item.deriv_c4 = deriv_ff[3];
   end

endmodule
`default_nettype wire

### design/diode_ladder_filter_derivative.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while rsp_tready holds; eight register stages, each with a valid bit.
// A stalled output holds its stage; upstream stages keep filling empty slots.
// Reset clears only the valid bits; the tanh table is constant logic.
// ----------------------------------------------------------------------------
// diode_ladder_filter_derivative: derivative core of a diode-ladder filter
// Returns the four capacitor voltage derivatives of a four-stage nonlinear
// ladder for one state vector per item, in signed Q16.16.
// ----------------------------------------------------------------------------
module diode_ladder_filter_derivative (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // sample_in, cutoff, resonance, volt_c1, volt_c2, volt_c3, volt_c4, zero pad
   input  wire logic [ddf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // deriv_c1, deriv_c2, deriv_c3, deriv_c4
   output logic [ddf_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   ddf_pkg::req_item_type                 req_item;
   ddf_pkg::rsp_item_type                 rsp_item;
   ddf_pkg::stage_load_type               load;

   logic signed [ddf_pkg::ARG_IN_W-1:0]   diff_a, diff_b, diff_c, diff_d, diff_e;
   logic [ddf_pkg::GAIN_W-1:0]            gain;
   logic signed [ddf_pkg::TANH_OUT_W-1:0] y_a, y_b, y_c, y_d, y_e;

   assign req_item  = ddf_pkg::req_item_type'(req_tdata);
   assign rsp_tdata = rsp_item;

   // Valid chain: one bit per stage, advance wherever the next stage frees up
   ddf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .load      (load)
   );

   // Stages 1-2: feedback (4K + 0.5) * volt_c4, cutoff gain, clamped differences
   ddf_front u_front (
      .clock  (clock),
      .load   (load),
      .item   (req_item),
      .diff_a (diff_a),
      .diff_b (diff_b),
      .diff_c (diff_c),
      .diff_d (diff_d),
      .diff_e (diff_e),
      .gain   (gain)
   );

   // Stages 3-6: five tanh units in parallel; b, c and d share the RECIP_G2 scale
   ddf_tanh u_tanh_a (
      .clock (clock), .load (load), .diff (diff_a), .recip (ddf_pkg::RECIP_VT2), .y (y_a)
   );
   ddf_tanh u_tanh_b (
      .clock (clock), .load (load), .diff (diff_b), .recip (ddf_pkg::RECIP_G2), .y (y_b)
   );
   ddf_tanh u_tanh_c (
      .clock (clock), .load (load), .diff (diff_c), .recip (ddf_pkg::RECIP_G2), .y (y_c)
   );
   ddf_tanh u_tanh_d (
      .clock (clock), .load (load), .diff (diff_d), .recip (ddf_pkg::RECIP_G2), .y (y_d)
   );
   ddf_tanh u_tanh_e (
      .clock (clock), .load (load), .diff (diff_e), .recip (ddf_pkg::RECIP_G6), .y (y_e)
   );

   // Stages 7-8: combine neighbor terms, scale by gain, round into the output
   ddf_back u_back (
      .clock (clock),
      .load  (load),
      .gain  (gain),
      .y_a   (y_a),
      .y_b   (y_b),
      .y_c   (y_c),
      .y_d   (y_d),
      .y_e   (y_e),
      .item  (rsp_item)
   );

endmodule
`default_nettype wire
